FILE: rtl/core/dcms_pkg.sv
`timescale 1ns / 1ps

package dcms_pkg;

  localparam int PHASE_W      = 32;
  localparam int SUM_W        = 34;
  localparam int PEAK_W       = 64;
  localparam int MAG_W        = 32;
  localparam int FREQ_IDX_W   = 7;
  localparam int BASE_STEP_W  = 31;
  localparam int NUM_FREQS_W  = 7;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_BASE_STEP = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_FREQS = 1'd1;

  localparam logic [BASE_STEP_W-1:0] BASE_STEP_RESET = 31'd33038210;
  localparam logic [NUM_FREQS_W-1:0] NUM_FREQS_RESET = 7'd64;

  // pi/2 in Q30, used to build the quarter-wave sine ROM.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [SUM_W+1:0] SUM_HI = 36'sh1_FFFF_FFFF;
  localparam logic signed [SUM_W+1:0] SUM_LO = -36'sh2_0000_0000;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W+1:0] v);
    logic signed [SUM_W-1:0] res;
    if (v > SUM_HI) begin
      res = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (v < SUM_LO) begin
      res = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      res = v[SUM_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/demodulated_cusum_max_scan.sv
`timescale 1ns / 1ps
// For each sample, each of the N active frequencies passes through
// nine sequencer steps around the one shared multiplier and the single-port sine ROM.
// On the series-end sample each result then passes through the iterative square root
// unit and waits for the output handshake; a clearing pass over all MAX_FREQS slots
// follows. Reset is synchronous and active low; it restores the register defaults and
// starts the same clearing pass of the state memories, taking no sample.

module demodulated_cusum_max_scan #(
  parameter int MAX_FREQS       = 64,
  parameter int SAMPLE_BITS     = 16,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dcms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dcms_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample, then zero fill
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // freq_index, max_magnitude, then zero fill
  output logic [39:0]                       out_tdata,
  output logic                              out_tlast
);
  import dcms_pkg::*;

  localparam int TAB_N   = 1 << TABLE_ADDR_BITS;
  localparam int PIDX_W  = TABLE_ADDR_BITS + 2;
  localparam int ROM_AW  = TABLE_ADDR_BITS + 1;
  localparam int ROM_W   = 16;
  localparam int SINE_W  = ROM_W + 1;
  localparam int SLOT_W  = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;
  localparam int K_W     = $clog2(MAX_FREQS + 1);
  localparam int MUL_W   = MAG_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = SUM_W + 2;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [3:0] R_WAIT     = 4'd0;
  localparam logic [3:0] R_PHASE    = 4'd1;
  localparam logic [3:0] R_SIN_ADDR = 4'd2;
  localparam logic [3:0] R_COS_ADDR = 4'd3;
  localparam logic [3:0] R_MUL_COS  = 4'd4;
  localparam logic [3:0] R_ACC_RE   = 4'd5;
  localparam logic [3:0] R_ACC_IM   = 4'd6;
  localparam logic [3:0] R_SQ_RE    = 4'd7;
  localparam logic [3:0] R_UPDATE   = 4'd8;

  localparam logic [3:0] E_WAIT  = 4'd0;
  localparam logic [3:0] E_START = 4'd1;
  localparam logic [3:0] E_SQRT  = 4'd2;

  localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(16384);

  typedef logic [ROM_W-1:0] sine_rom_t [TAB_N+1];

  // Quarter-wave sine in Q1.15 from an integer Taylor series in Q30.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   prod;
    longint unsigned   v;
    longint            acc;
    for (int j = 0; j <= TAB_N; j++) begin
      x    = (HALF_PI_Q30 * longint'(j)) >> TABLE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        prod = (term * x2) >> 30;
        case (n)
          1:       term = prod / 6;
          2:       term = prod / 20;
          3:       term = prod / 42;
          4:       term = prod / 72;
          5:       term = prod / 110;
          6:       term = prod / 156;
          7:       term = prod / 210;
          8:       term = prod / 272;
          default: term = prod / 342;
        endcase
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (longint'(acc) + 16384) >> 15;
      if (v > 32768) begin
        v = 32768;
      end
      rom[j] = ROM_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  function automatic logic [ROM_AW-1:0] quarter_addr(input logic [PIDX_W-1:0] idx);
    logic [ROM_AW-1:0] r;
    r = {1'b0, idx[TABLE_ADDR_BITS-1:0]};
    return idx[TABLE_ADDR_BITS] ? (ROM_AW'(TAB_N) - r) : r;
  endfunction

  function automatic logic signed [SINE_W-1:0] signed_sine(input logic neg,
                                                           input logic [ROM_W-1:0] mag);
    logic signed [SINE_W-1:0] s;
    s = $signed({1'b0, mag});
    return neg ? -s : s;
  endfunction

  logic [PHASE_W-1:0]       phase_mem [MAX_FREQS];
  logic signed [SUM_W-1:0]  re_mem    [MAX_FREQS];
  logic signed [SUM_W-1:0]  im_mem    [MAX_FREQS];
  logic [PEAK_W-1:0]        peak_mem  [MAX_FREQS];

  logic [2:0]               state_r;
  logic [3:0]               step_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [K_W-1:0]           count_r;
  logic [BASE_STEP_W-1:0]   base_step_r;
  logic [NUM_FREQS_W-1:0]   num_freqs_r;
  logic                     out_valid_r;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                     end_r;
  logic [PHASE_W-1:0]       inc_r;
  logic [PIDX_W-1:0]        p_r;
  logic signed [SINE_W-1:0] sin_r;
  logic [ROM_W-1:0]         rom_q_r;
  logic signed [PROD_W-1:0] mul_p_r;
  logic signed [SUM_W-1:0]  re_new_r;
  logic signed [SUM_W-1:0]  im_new_r;
  logic                     big_r;
  logic [PEAK_W-1:0]        sq_r;
  logic [FREQ_IDX_W-1:0]    out_freq_r;
  logic [MAG_W-1:0]         out_mag_r;
  logic                     out_last_r;

  logic [PHASE_W-1:0]       phase_q;
  logic signed [SUM_W-1:0]  re_q;
  logic signed [SUM_W-1:0]  im_q;
  logic [PEAK_W-1:0]        peak_q;

  logic [K_W-1:0]           eff_count;
  logic                     in_accept;
  logic                     slot_is_last;
  logic [PIDX_W-1:0]        cos_idx;
  logic [ROM_AW-1:0]        rom_addr;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_bias;
  logic signed [PROD_W-1:0] prod_shift;
  logic signed [ACC_W-1:0]  rnd_q;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [SUM_W-1:0]  acc_sat;
  logic signed [SUM_W-1:0]  mag_src;
  logic [SUM_W:0]           mag_ext;
  logic [SUM_W:0]           mag_abs;
  logic [PEAK_W-1:0]        sq_im;
  logic [PEAK_W:0]          sq_total;
  logic [PEAK_W-1:0]        sq_sat;
  logic                     mem_we;
  logic                     clearing;
  logic [PHASE_W-1:0]       phase_wd;
  logic signed [SUM_W-1:0]  re_wd;
  logic signed [SUM_W-1:0]  im_wd;
  logic [PEAK_W-1:0]        peak_wd;
  logic                     sqrt_start;
  logic                     sqrt_done;
  logic [MAG_W-1:0]         sqrt_root;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_mag_r, out_freq_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    if (num_freqs_r == '0) begin
      eff_count = K_W'(1);
    end else if (32'(num_freqs_r) > 32'(MAX_FREQS)) begin
      eff_count = K_W'(MAX_FREQS);
    end else begin
      eff_count = K_W'(num_freqs_r);
    end
  end

  assign slot_is_last = (K_W'(slot_r) == count_r - K_W'(1));
  assign cos_idx      = p_r + PIDX_W'(TAB_N);

  always_comb begin
    rom_addr = quarter_addr(p_r);
    if (step_r == R_COS_ADDR) begin
      rom_addr = quarter_addr(cos_idx);
    end
  end

  assign mag_src = (step_r == R_SQ_RE) ? im_new_r : re_new_r;
  assign mag_ext = {mag_src[SUM_W-1], mag_src};
  assign mag_abs = mag_src[SUM_W-1] ? ((SUM_W+1)'(0) - mag_ext) : mag_ext;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      R_MUL_COS: begin
        mul_a = MUL_W'(sample_r);
        mul_b = MUL_W'(signed_sine(cos_idx[PIDX_W-1], rom_q_r));
      end
      R_ACC_RE: begin
        mul_a = MUL_W'(sample_r);
        mul_b = MUL_W'(sin_r);
      end
      R_ACC_IM, R_SQ_RE: begin
        mul_a = $signed({1'b0, mag_abs[MAG_W-1:0]});
        mul_b = $signed({1'b0, mag_abs[MAG_W-1:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Products are rounded to an integer with halves toward positive infinity.
  assign prod_bias  = mul_p_r + RND_BIAS;
  assign prod_shift = prod_bias >>> 15;
  assign rnd_q      = prod_shift[ACC_W-1:0];
  assign acc_sum    = ((step_r == R_ACC_IM) ? ACC_W'(im_q) : ACC_W'(re_q)) + rnd_q;
  assign acc_sat    = sat_sum(acc_sum);

  assign sq_im    = big_r ? {PEAK_W{1'b1}} : mul_p_r[PEAK_W-1:0];
  assign sq_total = {1'b0, sq_r} + {1'b0, sq_im};
  assign sq_sat   = sq_total[PEAK_W] ? {PEAK_W{1'b1}} : sq_total[PEAK_W-1:0];

  assign clearing = (state_r == ST_CLEAR);
  assign mem_we   = clearing || (state_r == ST_RUN && step_r == R_UPDATE);
  assign phase_wd = clearing ? '0 : phase_q + inc_r;
  assign re_wd    = clearing ? '0 : re_new_r;
  assign im_wd    = clearing ? '0 : im_new_r;
  assign peak_wd  = clearing ? '0 : ((sq_sat > peak_q) ? sq_sat : peak_q);

  assign sqrt_start = (state_r == ST_EMIT) && (step_r == E_START);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      phase_mem[slot_r] <= phase_wd;
      re_mem[slot_r]    <= re_wd;
      im_mem[slot_r]    <= im_wd;
      peak_mem[slot_r]  <= peak_wd;
    end
    phase_q <= phase_mem[slot_r];
    re_q    <= re_mem[slot_r];
    im_q    <= im_mem[slot_r];
    peak_q  <= peak_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    rom_q_r <= SINE_ROM[rom_addr];
    mul_p_r <= mul_a * mul_b;
    big_r   <= |mag_abs[SUM_W:MAG_W];
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_tdata[SAMPLE_BITS-1:0];
      end_r    <= in_tlast;
      count_r  <= eff_count;
      inc_r    <= {1'b0, base_step_r};
    end
    if (state_r == ST_RUN) begin
      case (step_r)
        R_PHASE:    p_r      <= phase_q[PHASE_W-1 -: PIDX_W];
        R_COS_ADDR: sin_r    <= signed_sine(p_r[PIDX_W-1], rom_q_r);
        R_ACC_RE:   re_new_r <= acc_sat;
        R_ACC_IM:   im_new_r <= acc_sat;
        R_SQ_RE:    sq_r     <= big_r ? {PEAK_W{1'b1}} : mul_p_r[PEAK_W-1:0];
        R_UPDATE:   inc_r    <= inc_r + {1'b0, base_step_r};
        default: begin
        end
      endcase
    end
    if (state_r == ST_EMIT && step_r == E_SQRT && sqrt_done) begin
      out_freq_r <= FREQ_IDX_W'(K_W'(slot_r) + K_W'(1));
      out_mag_r  <= sqrt_root;
      out_last_r <= slot_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_step_r <= BASE_STEP_RESET;
      num_freqs_r <= NUM_FREQS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_STEP: base_step_r <= cfg_data[BASE_STEP_W-1:0];
        REG_NUM_FREQS: num_freqs_r <= cfg_data[NUM_FREQS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          if (slot_r == SLOT_W'(MAX_FREQS - 1)) begin
            slot_r  <= '0;
            state_r <= ST_IDLE;
          end else begin
            slot_r <= slot_r + SLOT_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            slot_r  <= '0;
            step_r  <= R_WAIT;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step_r == R_UPDATE) begin
            step_r <= R_WAIT;
            if (slot_is_last) begin
              slot_r  <= '0;
              state_r <= end_r ? ST_EMIT : ST_IDLE;
            end else begin
              slot_r <= slot_r + SLOT_W'(1);
            end
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        ST_EMIT: begin
          if (step_r == E_SQRT) begin
            if (sqrt_done) begin
              out_valid_r <= 1'b1;
              state_r     <= ST_OUT;
            end
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        ST_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            step_r      <= E_WAIT;
            if (slot_is_last) begin
              slot_r  <= '0;
              state_r <= ST_CLEAR;
            end else begin
              slot_r  <= slot_r + SLOT_W'(1);
              state_r <= ST_EMIT;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  dcms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (peak_q),
    .done     (sqrt_done),
    .root_out (sqrt_root)
  );

endmodule

FILE: rtl/core/dcms_sqrt.sv
`timescale 1ns / 1ps

module dcms_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dcms_pkg::PEAK_W-1:0]  radicand,
  output logic                         done,
  output logic [dcms_pkg::MAG_W-1:0]   root_out
);
  import dcms_pkg::*;

  localparam int REM_W = MAG_W + 3;
  localparam int CNT_W = $clog2(MAG_W);

  logic [PEAK_W-1:0] rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [MAG_W-1:0]  root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // Two radicand bits enter per cycle; one root bit is decided per cycle.
  assign rem_shift = {rem_r[REM_W-3:0], rad_r[PEAK_W-1 -: 2]};
  assign trial     = {1'b0, root_r, 2'b01};
  assign fits      = (rem_shift >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MAG_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[PEAK_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_shift - trial) : rem_shift;
      root_r <= {root_r[MAG_W-2:0], fits};
    end
  end

  // Round to nearest with halves up: the remainder exceeds the root exactly
  // when the value is at or beyond the midpoint to the next integer.
  always_comb begin
    root_out = root_r;
    if (rem_r > {3'b000, root_r} && !(&root_r)) begin
      root_out = root_r + MAG_W'(1);
    end
  end

  assign done = done_r;

endmodule
